/* rtl/fir4b_pkg.sv */
// Shared types, sizes and codes of the four-bank FIR filter.
package fir4b_pkg;

    localparam int TAPS  = 64;
    localparam int BANKS = 4;

    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int CA_W   = (BANKS * TAPS > 1) ? $clog2(BANKS * TAPS) : 1;
    localparam int ACC_W  = 32 + $clog2(TAPS);
    localparam int FRAC_W = 15;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample_in;
        logic [1:0]         coef_bank;
        logic [5:0]         coef_index;
        logic signed [15:0] coef_value;
    } req_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               clipped;
    } rsp_t;

    // Control word fields that leave the sequencer.
    typedef struct packed {
        logic ready;
        logic rd_en;
        logic out_load;
    } ctl_t;

    // Conditions that the datapath reports back to the sequencer.
    typedef struct packed {
        logic sample_go;
        logic tap_last;
        logic out_free;
    } stat_t;

endpackage

/* rtl/fir4b_seq.sv */
// Microcoded sequencer: step counter, control ROM and jump logic.
module fir4b_seq
(
    input  logic            clk,
    input  logic            rst_n,
    input  fir4b_pkg::stat_t stat,
    output fir4b_pkg::ctl_t  ctl
);

    localparam logic [2:0] STEP_IDLE  = 3'd0;
    localparam logic [2:0] STEP_MAC   = 3'd1;
    localparam logic [2:0] STEP_DRN_A = 3'd2;
    localparam logic [2:0] STEP_DRN_B = 3'd3;
    localparam logic [2:0] STEP_OUT   = 3'd4;

    localparam logic [1:0] JC_ALWAYS   = 2'd0;
    localparam logic [1:0] JC_SAMPLE   = 2'd1;
    localparam logic [1:0] JC_TAP_LAST = 2'd2;
    localparam logic [1:0] JC_OUT_FREE = 2'd3;

    typedef struct packed {
        fir4b_pkg::ctl_t ctl;
        logic [1:0]      jc;
        logic [2:0]      target;
    } uword_t;

    function automatic uword_t rom(input logic [2:0] step);
        uword_t w;
        w = '{ctl: '{ready: 1'b0, rd_en: 1'b0, out_load: 1'b0},
              jc: JC_ALWAYS, target: STEP_IDLE};
        case (step)
            STEP_IDLE:
            begin
                w.ctl.ready = 1'b1;
                w.jc        = JC_SAMPLE;
                w.target    = STEP_MAC;
            end
            STEP_MAC:
            begin
                w.ctl.rd_en = 1'b1;
                w.jc        = JC_TAP_LAST;
                w.target    = STEP_DRN_A;
            end
            STEP_DRN_A:
            begin
                w.target = STEP_DRN_B;
            end
            STEP_DRN_B:
            begin
                w.target = STEP_OUT;
            end
            STEP_OUT:
            begin
                w.ctl.out_load = 1'b1;
                w.jc           = JC_OUT_FREE;
                w.target       = STEP_IDLE;
            end
            default:
            begin
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    logic [2:0] step_reg;
    logic [2:0] step_next;
    uword_t     uw;
    logic       take;

    assign uw  = rom(step_reg);
    assign ctl = uw.ctl;

    always_comb
    begin
        case (uw.jc)
            JC_ALWAYS:   take = 1'b1;
            JC_SAMPLE:   take = stat.sample_go;
            JC_TAP_LAST: take = stat.tap_last;
            JC_OUT_FREE: take = stat.out_free;
            default:     take = 1'b1;
        endcase
        step_next = take ? uw.target : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* rtl/fir4b_dp.sv */
// Datapath: delay line, coefficient store, multiply-accumulate and output register.
module fir4b_dp
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_go,
    input  fir4b_pkg::req_t  req,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_wdata,
    input  logic             rsp_stall,
    input  fir4b_pkg::ctl_t  ctl,
    output fir4b_pkg::stat_t stat,
    output logic             rsp_valid,
    output fir4b_pkg::rsp_t  rsp
);

    localparam int TAPS  = fir4b_pkg::TAPS;
    localparam int BANKS = fir4b_pkg::BANKS;
    localparam int TAP_W = fir4b_pkg::TAP_W;
    localparam int BANK_W = fir4b_pkg::BANK_W;
    localparam int CA_W  = fir4b_pkg::CA_W;
    localparam int ACC_W = fir4b_pkg::ACC_W;

    logic signed [15:0] dl_mem [TAPS];
    logic signed [15:0] cf_mem [BANKS*TAPS];

    logic [TAPS-1:0]    dl_vld_reg;
    logic [TAP_W-1:0]   wptr_reg;
    logic [TAP_W-1:0]   wptr_next;
    logic [TAP_W-1:0]   tap_reg;
    logic [BANK_W-1:0]  bank_reg;
    logic [1:0]         fsel_reg;

    logic               sample_go;
    logic               coef_go;
    logic [TAP_W-1:0]   dl_addr;
    logic [CA_W-1:0]    cf_rd_addr;
    logic [CA_W-1:0]    cf_wr_addr;
    logic [BANK_W-1:0]  bank_pick;

    logic signed [15:0] dl_q_reg;
    logic               dl_ok_reg;
    logic signed [15:0] cf_q_reg;
    logic               p1_vld_reg;
    logic signed [15:0] dl_samp;
    logic signed [31:0] prod_reg;
    logic               p2_vld_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic signed [ACC_W-1:0] q_shift;
    logic signed [ACC_W-1:0] q_trunc;
    fir4b_pkg::rsp_t    rsp_next;
    logic               rsp_vld_reg;
    fir4b_pkg::rsp_t    rsp_reg;
    logic               out_free;

    assign sample_go = req_go && (req.kind == fir4b_pkg::KIND_SAMPLE);
    assign coef_go   = req_go && (req.kind == fir4b_pkg::KIND_COEF)
                       && ({30'd0, req.coef_bank} < 32'(BANKS))
                       && ({26'd0, req.coef_index} < 32'(TAPS));

    assign wptr_next = (wptr_reg == TAP_W'(TAPS - 1)) ? '0 : wptr_reg + 1'b1;

    // Tap k sits k words behind the newest sample, wrapping round the buffer.
    assign dl_addr = (wptr_reg >= tap_reg) ? (wptr_reg - tap_reg)
                                           : (wptr_reg + TAP_W'(TAPS) - tap_reg);

    assign bank_pick  = ({30'd0, fsel_reg} >= 32'(BANKS)) ? BANK_W'(BANKS - 1)
                                                           : BANK_W'(fsel_reg);
    assign cf_rd_addr = CA_W'(CA_W'(bank_reg) * CA_W'(TAPS)) + CA_W'(tap_reg);
    assign cf_wr_addr = CA_W'(CA_W'(req.coef_bank) * CA_W'(TAPS)) + CA_W'(req.coef_index);

    always_ff @(posedge clk)
    begin
        if (sample_go)
        begin
            dl_mem[wptr_next] <= req.sample_in;
        end
        if (coef_go)
        begin
            cf_mem[cf_wr_addr] <= req.coef_value;
        end
        dl_q_reg <= dl_mem[dl_addr];
        cf_q_reg <= cf_mem[cf_rd_addr];
        dl_ok_reg <= dl_vld_reg[dl_addr];
    end

    assign dl_samp = dl_ok_reg ? dl_q_reg : 16'sd0;

    always_ff @(posedge clk)
    begin
        prod_reg <= dl_samp * cf_q_reg;
        rsp_reg  <= (ctl.out_load && out_free) ? rsp_next : rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_vld_reg  <= '0;
            wptr_reg    <= '0;
            tap_reg     <= '0;
            bank_reg    <= '0;
            fsel_reg    <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            acc_reg     <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fsel_reg <= cfg_wdata;
            end
            if (sample_go)
            begin
                dl_vld_reg[wptr_next] <= 1'b1;
                wptr_reg <= wptr_next;
                bank_reg <= bank_pick;
                tap_reg  <= '0;
            end
            else if (ctl.rd_en && !stat.tap_last)
            begin
                tap_reg <= tap_reg + 1'b1;
            end
            p1_vld_reg <= ctl.rd_en;
            p2_vld_reg <= p1_vld_reg;
            if (sample_go)
            begin
                acc_reg <= '0;
            end
            else if (p2_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (ctl.out_load && out_free)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // Arithmetic shift rounds toward minus infinity; a negative value with
    // fraction bits left over is nudged back up to round toward zero.
    always_comb
    begin
        q_shift = acc_reg >>> fir4b_pkg::FRAC_W;
        q_trunc = q_shift;
        if (acc_reg[ACC_W-1] && (acc_reg[fir4b_pkg::FRAC_W-1:0] != '0))
        begin
            q_trunc = q_shift + ACC_W'(1);
        end
        if (q_trunc > fir4b_pkg::SAT_MAX)
        begin
            rsp_next.sample_out = 16'sh7fff;
            rsp_next.clipped    = 1'b1;
        end
        else if (q_trunc < fir4b_pkg::SAT_MIN)
        begin
            rsp_next.sample_out = 16'sh8000;
            rsp_next.clipped    = 1'b1;
        end
        else
        begin
            rsp_next.sample_out = q_trunc[15:0];
            rsp_next.clipped    = 1'b0;
        end
    end

    assign out_free       = !rsp_vld_reg || !rsp_stall;
    assign stat.sample_go = sample_go;
    assign stat.tap_last  = (tap_reg == TAP_W'(TAPS - 1));
    assign stat.out_free  = out_free;
    assign rsp_valid      = rsp_vld_reg;
    assign rsp            = rsp_reg;

endmodule

/* rtl/fir_filter_four_banks_core.sv */
// Top level of the four-bank FIR filter.
// A sample word is accepted and then handled in order: the single
// multiply-accumulate unit takes one tap a cycle from the delay-line and
// coefficient memories for all TAPS taps, then the last product is formed,
// added into the accumulator, and then rounded, saturated and loaded into the
// output register. No new word is accepted during that run, and if the
// previous result is still stalled when the new one is ready, the block waits
// until it leaves. A coefficient-write word gives no result and leaves the
// block idle, so such words can follow each other back to back. A finished
// result waits in the output register while the next word is accepted.
// filter_select is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce. The
// delay line reads as zero until filled.
module fir_filter_four_banks_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  fir4b_pkg::req_t req,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_wdata,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output fir4b_pkg::rsp_t rsp
);

    fir4b_pkg::ctl_t  ctl;
    fir4b_pkg::stat_t stat;
    logic             req_go;

    assign req_stall = !ctl.ready;
    assign req_go    = req_valid && ctl.ready;

    fir4b_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    fir4b_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_go    (req_go),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp_stall (rsp_stall),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

/* rtl/fir4b_checker.sv */
// Port-level checks of the four-bank FIR filter and their binding.
module fir4b_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input fir4b_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input fir4b_pkg::rsp_t rsp
);

    // A waiting result word holds until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    // A sample word keeps the block busy in the following cycle.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.kind == fir4b_pkg::KIND_SAMPLE) |=> req_stall)
        else $error("sample word did not start the filter");

    // A coefficient write leaves the block free for the next word.
    a_coef_free: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.kind == fir4b_pkg::KIND_COEF) |=> !req_stall)
        else $error("coefficient write stalled the input");

    // A saturated result sits on one of the two limits.
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.clipped |->
            (rsp.sample_out == 16'sh7fff) || (rsp.sample_out == 16'sh8000))
        else $error("clipped result is not at a limit");

    // A new result appears only at the end of a busy filtering run.
    a_rsp_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result word appeared without a filtering run");

endmodule

bind fir_filter_four_banks_core fir4b_checker u_fir4b_checker (.*);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the four-bank FIR filter core: directed and random traffic.
`timescale 1ns / 100ps

module tb_top;

    typedef enum int {FILL_SMALL, FILL_FULL, FILL_NEG_UNIT, FILL_HALF} fill_mode_t;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 80;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    fir4b_pkg::req_t   req       = '0;
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_wdata = 2'd0;
    logic              rsp_stall = 1'b0;
    logic              req_stall;
    logic              rsp_valid;
    fir4b_pkg::rsp_t   rsp;

    // Shadow copy of the filter state.
    logic signed [15:0] hist_model [fir4b_pkg::TAPS];
    logic signed [15:0] coef_model [fir4b_pkg::BANKS*fir4b_pkg::TAPS];
    logic [1:0]         filter_sel_model;

    fir4b_pkg::rsp_t pending_filtered [$];

    int err_count     = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    fir_filter_four_banks_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Updates the shadow state for one accepted word and, for a sample word, queues the filtered sample.
    function automatic void filter_predict(input fir4b_pkg::req_t w);
        int              bank;
        longint          acc;
        longint          quot;
        fir4b_pkg::rsp_t r;
        if (w.kind == fir4b_pkg::KIND_COEF)
        begin
            if (int'(w.coef_bank) < fir4b_pkg::BANKS && int'(w.coef_index) < fir4b_pkg::TAPS)
                coef_model[int'(w.coef_bank) * fir4b_pkg::TAPS + int'(w.coef_index)] =
                    w.coef_value;
            return;
        end
        bank = (int'(filter_sel_model) >= fir4b_pkg::BANKS) ? fir4b_pkg::BANKS - 1
                                                             : int'(filter_sel_model);
        for (int k = fir4b_pkg::TAPS - 1; k > 0; k--)
            hist_model[k] = hist_model[k-1];
        hist_model[0] = w.sample_in;
        acc = 0;
        for (int k = 0; k < fir4b_pkg::TAPS; k++)
            acc += longint'(hist_model[k])
                   * longint'(coef_model[bank * fir4b_pkg::TAPS + k]);
        // Integer division of signed operands truncates toward zero.
        quot = acc / (longint'(1) << fir4b_pkg::FRAC_W);
        r.clipped = 1'b0;
        if (quot > 32767)
        begin
            quot      = 32767;
            r.clipped = 1'b1;
        end
        else if (quot < -32768)
        begin
            quot      = -32768;
            r.clipped = 1'b1;
        end
        r.sample_out = quot[15:0];
        pending_filtered.push_back(r);
    endfunction

    function automatic fir4b_pkg::req_t sample_word(input logic signed [15:0] s);
        logic [63:0]     bits;
        fir4b_pkg::req_t w;
        bits        = {$urandom, $urandom};
        w           = bits[$bits(fir4b_pkg::req_t)-1:0];
        w.kind      = fir4b_pkg::KIND_SAMPLE;
        w.sample_in = s;
        return w;
    endfunction

    function automatic fir4b_pkg::req_t coef_word(input logic [1:0] bank,
                                                  input logic [5:0] idx,
                                                  input logic signed [15:0] val);
        logic [63:0]     bits;
        fir4b_pkg::req_t w;
        bits         = {$urandom, $urandom};
        w            = bits[$bits(fir4b_pkg::req_t)-1:0];
        w.kind       = fir4b_pkg::KIND_COEF;
        w.coef_bank  = bank;
        w.coef_index = idx;
        w.coef_value = val;
        return w;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'sd32767;
            1:       return -16'sd32768;
            2:       return 16'sd0;
            3, 4, 5: return 16'($signed($urandom_range(511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_coef();
        case ($urandom_range(9))
            0:       return 16'sd32767;
            1:       return -16'sd32768;
            2, 3:    return 16'($urandom);
            default: return 16'($signed($urandom_range(8191)) - 4096);
        endcase
    endfunction

    function automatic fir4b_pkg::req_t rand_word();
        if ($urandom_range(9) < 6)
            return sample_word(rand_sample());
        return coef_word(2'($urandom), 6'($urandom), rand_coef());
    endfunction

    // Offers one word, with random idle cycles first, and returns once it is taken.
    task automatic send_word(input fir4b_pkg::req_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        filter_predict(w);
    endtask

    // Drains all outstanding results, then gives the core time to finish.
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_filtered.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_filter_select(input logic [1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        filter_sel_model = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic fill_bank(input logic [1:0] bank, input fill_mode_t mode);
        logic signed [15:0] val;
        for (int k = 0; k < fir4b_pkg::TAPS; k++)
        begin
            case (mode)
                FILL_SMALL:    val = 16'($signed($urandom_range(4095)) - 2048);
                FILL_FULL:     val = 16'($urandom);
                FILL_NEG_UNIT: val = (k == 0) ? -16'sd32768 : 16'sd0;
                default:       val = (k == 0) ? 16'sd16384 : 16'sd0;
            endcase
            send_word(coef_word(bank, 6'(k), val));
        end
    endtask

    task automatic test_coef_load();
        fill_bank(2'd0, FILL_SMALL);
        fill_bank(2'd1, FILL_FULL);
        fill_bank(2'd2, FILL_NEG_UNIT);
        fill_bank(2'd3, FILL_HALF);
        settle();
    endtask

    // Bank 2 holds minus one at the newest tap, so the output is the negated sample, saturated where it overflows.
    task automatic test_unit_gain();
        write_filter_select(2'd2);
        send_word(sample_word(16'sd32767));
        send_word(sample_word(-16'sd32768));
        send_word(sample_word(16'sd0));
        send_word(sample_word(-16'sd1));
        send_word(sample_word(16'sd1));
        settle();
    endtask

    // Bank 3 halves the newest sample: odd negative inputs show truncation toward zero.
    task automatic test_truncation();
        write_filter_select(2'd3);
        send_word(sample_word(-16'sd1));
        send_word(sample_word(-16'sd3));
        send_word(sample_word(16'sd3));
        send_word(sample_word(16'sd32767));
        send_word(sample_word(-16'sd32768));
        settle();
    endtask

    task automatic test_saturation();
        write_filter_select(2'd1);
        repeat (3) send_word(sample_word(16'sd32767));
        repeat (3) send_word(sample_word(-16'sd32768));
        settle();
    endtask

    task automatic test_coef_extremes();
        send_word(coef_word(2'd0, 6'd0, 16'sd32767));
        send_word(coef_word(2'd0, 6'd63, -16'sd32768));
        send_word(coef_word(2'd3, 6'd63, 16'sd32767));
        settle();
        write_filter_select(2'd0);
        send_word(sample_word(16'sd32767));
        send_word(sample_word(-16'sd32768));
        send_word(sample_word(16'sd100));
        settle();
    endtask

    task automatic test_random_traffic();
        logic [1:0] sel_order [8];
        int         idle_plan [4];
        int         stall_plan [4];
        sel_order  = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};
        idle_plan  = '{0, 76, 0, 12};
        stall_plan = '{0, 0, 76, 12};
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = idle_plan[phase];
            stall_pct     = stall_plan[phase];
            for (int part = 0; part < 2; part++)
            begin
                settle();
                write_filter_select(sel_order[phase * 2 + part]);
                repeat (115) send_word(rand_word());
            end
        end
        settle();
    endtask

    initial
    begin
        for (int k = 0; k < fir4b_pkg::TAPS; k++)
            hist_model[k] = '0;
        for (int k = 0; k < fir4b_pkg::BANKS * fir4b_pkg::TAPS; k++)
            coef_model[k] = '0;
        filter_sel_model = 2'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_coef_load();
        test_unit_gain();
        test_truncation();
        test_saturation();
        test_coef_extremes();
        test_random_traffic();

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // Compares each delivered word with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        fir4b_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_filtered.size() == 0)
            begin
                $error("unexpected result word: sample_out %0d, clipped %0b",
                       rsp.sample_out, rsp.clipped);
                err_count++;
            end
            else
            begin
                want = pending_filtered.pop_front();
                if (rsp.sample_out !== want.sample_out)
                begin
                    $error("sample_out: expected %0d, got %0d", want.sample_out, rsp.sample_out);
                    err_count++;
                end
                if (rsp.clipped !== want.clipped)
                begin
                    $error("clipped: expected %0b, got %0b", want.clipped, rsp.clipped);
                    err_count++;
                end
            end
        end
    end

    // Ends the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
